@@ src/bpa_pkg.sv @@
package bpa_pkg;

	localparam int LEAVES_DEF = 1024;
	localparam int ORD_W = 5;
	localparam logic [10:0] PAGE_COUNT_RST = 11'd1024;
	localparam logic [6:0] REF_MAX = 7'h7f;

	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;
	localparam logic [1:0] OP_CREF  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_SPACE  = 3'd1;
	localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
	localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
	localparam logic [2:0] ST_REF_RANGE = 3'd4;

	// One tree node: invalid mark and the order of its largest free block.
	typedef struct packed {
		logic             inv;
		logic [ORD_W-1:0] ord;
	} node_t;

	localparam node_t NODE_INV = '{inv: 1'b1, ord: '0};

	function automatic logic [ORD_W-1:0] node_eff(input node_t n);
		node_eff = n.inv ? '0 : n.ord;
	endfunction

	// Order needed for a request: one more than the rounded-up log2 of the size.
	function automatic logic [ORD_W-1:0] need_order(input logic [10:0] req);
		logic [ORD_W-1:0] r;
		r = ORD_W'(12);
		for (int n = 11; n >= 0; n--) begin
			if ({1'b0, req} <= (12'd1 << n))
				r = ORD_W'(n + 1);
		end
		need_order = r;
	endfunction

endpackage

@@ src/bpa_ram.sv @@
module bpa_ram #(
	parameter int W = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ src/bpa_merge.sv @@
module bpa_merge
	import bpa_pkg::*;
(
	input  node_t            lhs,
	input  node_t            rhs,
	input  logic [ORD_W-1:0] power,
	output node_t            parent
);

	always_comb begin
		parent = NODE_INV;
		if (!lhs.inv && !rhs.inv) begin
			// Two fully free buddies join into one block of the parent's size.
			if (lhs.ord == rhs.ord && ({1'b0, rhs.ord} + 1'b1) == {1'b0, power})
				parent = '{inv: 1'b0, ord: lhs.ord + 1'b1};
			else
				parent = '{inv: 1'b0, ord: (lhs.ord > rhs.ord) ? lhs.ord : rhs.ord};
		end else if (!rhs.inv) begin
			parent = rhs;
		end else if (!lhs.inv) begin
			parent = lhs;
		end
	end

endmodule

@@ src/buddy_page_allocator.sv @@
// Binary buddy page allocator. One request is taken at a time; s_tready is high only
// while the sequencer is idle, and the result waits in an output register until taken.
// All tree work goes through one node-order memory with a single registered read port
// and one shared merge unit, so the tree levels are visited one after another. Init
// writes every leaf and then rebuilds the inner nodes from the bottom of the tree up.
// After reset a clearing pass marks every node invalid before the first request is
// accepted; configuration writes are taken at any time.
module buddy_page_allocator
	import bpa_pkg::*;
#(
	parameter int LEAVES = LEAVES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // op[1:0], req_pages[12:2], block_offset[22:13], ref_delta[30:23]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // status[2:0], alloc_offset[12:3], ref_count[19:13], avail_pages[30:20]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);

	localparam int TL = 1 << $clog2(LEAVES);
	localparam int LW = $clog2(TL);
	localparam int NODES = 2 * TL - 1;
	localparam int NW = LW + 1;
	localparam int FCW = LW + 1;
	localparam int AW = LW + 2;
	localparam int OW = (LW + 1 > 10) ? LW + 1 : 10;
	localparam int CW = (NW > 11) ? NW : 11;
	localparam logic [ORD_W-1:0] TOP = ORD_W'(LW + 1);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_INIT  = 5'd2;
	localparam logic [4:0] S_IRL   = 5'd3;
	localparam logic [4:0] S_IRR   = 5'd4;
	localparam logic [4:0] S_IWR   = 5'd5;
	localparam logic [4:0] S_AROOT = 5'd6;
	localparam logic [4:0] S_ACHK  = 5'd7;
	localparam logic [4:0] S_ARD   = 5'd8;
	localparam logic [4:0] S_ADN   = 5'd9;
	localparam logic [4:0] S_ATAKE = 5'd10;
	localparam logic [4:0] S_AREF  = 5'd11;
	localparam logic [4:0] S_URD   = 5'd12;
	localparam logic [4:0] S_UWR   = 5'd13;
	localparam logic [4:0] S_FRD   = 5'd14;
	localparam logic [4:0] S_FCHK  = 5'd15;
	localparam logic [4:0] S_RESP  = 5'd16;

	logic [4:0]       state_q;
	logic [NW-1:0]    i_q;
	logic [ORD_W-1:0] k_q;
	node_t            cur_q;
	node_t            lval_q;
	logic [1:0]       op_q;
	logic [10:0]      req_q;
	logic [7:0]       delta_q;
	logic [10:0]      page_count_q;
	logic [FCW-1:0]   fc_q;
	logic [2:0]       res_status_q;
	logic [9:0]       res_aoff_q;
	logic [6:0]       res_rc_q;
	logic             m_tvalid_q;
	logic [31:0]      m_tdata_q;

	node_t            ord_rdata;
	node_t            ord_wdata;
	logic             ord_we;
	logic [NW-1:0]    ord_waddr;
	logic [NW-1:0]    ord_raddr;
	logic             refs_we;
	logic [6:0]       refs_wdata;
	logic [6:0]       refs_rdata;
	node_t            mrg_l;
	logic [ORD_W-1:0] mrg_pow;
	node_t            merged;

	logic [NW-1:0]    lchild;
	logic [NW-1:0]    rchild;
	logic [NW-1:0]    sib;
	logic [NW-1:0]    parent;
	logic [NW-1:0]    leaf_off;
	logic             leaf_inv;
	logic [ORD_W-1:0] need;
	logic             found;
	logic             accept;
	logic [1:0]       in_op;
	logic [10:0]      in_req;
	logic [9:0]       in_off;
	logic signed [8:0] nv;
	logic             nv_ok;
	logic [AW-1:0]    aoff;
	logic [FCW-1:0]   bsize;
	logic [FCW:0]     fc_sum;

	assign in_op  = s_tdata[1:0];
	assign in_req = s_tdata[12:2];
	assign in_off = s_tdata[22:13];

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign lchild   = {i_q[NW-2:0], 1'b1};
	assign rchild   = lchild + 1'b1;
	assign sib      = i_q[0] ? i_q + 1'b1 : i_q - 1'b1;
	assign parent   = (i_q - 1'b1) >> 1;
	assign leaf_off = i_q - NW'(TL - 1);
	assign leaf_inv = CW'(leaf_off) >= CW'(page_count_q);
	assign need     = need_order(req_q);
	assign found    = (ord_rdata == node_t'('0));

	assign nv    = $signed({2'b00, refs_rdata}) + $signed({delta_q[7], delta_q});
	assign nv_ok = (nv >= 9'sd1) && (nv <= $signed({2'b00, REF_MAX}));
	assign bsize = FCW'(1) << (k_q - 1'b1);
	assign aoff  = ((AW'(i_q) + 1'b1) << (k_q - 1'b1)) - AW'(TL);
	assign fc_sum = {1'b0, fc_q} + {1'b0, bsize};

	assign mrg_l   = (state_q == S_IWR) ? lval_q : cur_q;
	assign mrg_pow = (state_q == S_IWR) ? k_q : k_q + 1'b1;

	bpa_merge u_merge (
		.lhs    (mrg_l),
		.rhs    (ord_rdata),
		.power  (mrg_pow),
		.parent (merged)
	);

	bpa_ram #(.W($bits(node_t)), .DEPTH(NODES)) u_order_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	bpa_ram #(.W(7), .DEPTH(NODES)) u_refs_ram (
		.clk   (clk),
		.we    (refs_we),
		.waddr (i_q),
		.wdata (refs_wdata),
		.raddr (i_q),
		.rdata (refs_rdata)
	);

	always_comb begin
		ord_raddr  = '0;
		ord_we     = 1'b0;
		ord_waddr  = i_q;
		ord_wdata  = merged;
		refs_we    = 1'b0;
		refs_wdata = '0;
		unique case (state_q)
			S_CLR: begin
				ord_we    = 1'b1;
				ord_wdata = NODE_INV;
				refs_we   = 1'b1;
			end
			S_INIT: begin
				ord_we    = i_q >= NW'(TL - 1);
				ord_wdata = '{inv: leaf_inv, ord: ORD_W'(1)};
				refs_we   = 1'b1;
			end
			S_IRL:   ord_raddr = lchild;
			S_IRR:   ord_raddr = rchild;
			S_IWR:   ord_we = 1'b1;
			S_ARD:   ord_raddr = lchild;
			S_ATAKE: begin
				ord_we    = 1'b1;
				ord_wdata = '0;
			end
			S_AREF: begin
				refs_we    = 1'b1;
				refs_wdata = (refs_rdata < REF_MAX) ? refs_rdata + 1'b1 : refs_rdata;
			end
			S_URD:   ord_raddr = sib;
			S_UWR: begin
				ord_we    = 1'b1;
				ord_waddr = parent;
			end
			S_FRD:   ord_raddr = i_q;
			S_FCHK: begin
				if (found && op_q == OP_FREE) begin
					ord_we     = 1'b1;
					ord_wdata  = '{inv: 1'b0, ord: k_q};
					refs_we    = 1'b1;
					refs_wdata = (refs_rdata != '0) ? refs_rdata - 1'b1 : refs_rdata;
				end else if (found && op_q == OP_CREF && nv_ok) begin
					refs_we    = 1'b1;
					refs_wdata = nv[6:0];
				end
			end
			default: ord_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			i_q          <= '0;
			k_q          <= '0;
			cur_q        <= '0;
			lval_q       <= '0;
			op_q         <= OP_INIT;
			req_q        <= '0;
			delta_q      <= '0;
			page_count_q <= PAGE_COUNT_RST;
			fc_q         <= '0;
			res_status_q <= ST_OK;
			res_aoff_q   <= '0;
			res_rc_q     <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				page_count_q <= cfg_data;
			// A new result loaded in S_RESP replaces the one being taken.
			if (m_tvalid_q && m_tready && state_q != S_RESP)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_CLR: begin
					if (i_q == NW'(NODES - 1))
						state_q <= S_IDLE;
					else
						i_q <= i_q + 1'b1;
				end
				S_IDLE: begin
					if (accept) begin
						op_q         <= in_op;
						req_q        <= in_req;
						delta_q      <= s_tdata[30:23];
						res_status_q <= ST_OK;
						res_aoff_q   <= '0;
						res_rc_q     <= '0;
						unique case (in_op)
							OP_INIT: begin
								i_q     <= '0;
								fc_q    <= (CW'(page_count_q) < CW'(TL)) ?
								           FCW'(page_count_q) : FCW'(TL);
								state_q <= S_INIT;
							end
							OP_ALLOC: begin
								if (in_req == '0) begin
									res_status_q <= ST_ZERO_SIZE;
									state_q      <= S_RESP;
								end else begin
									state_q <= S_AROOT;
								end
							end
							OP_FREE, OP_CREF: begin
								if (OW'(in_off) >= OW'(TL)) begin
									res_status_q <= ST_NOT_ALLOC;
									state_q      <= S_RESP;
								end else begin
									i_q     <= NW'(TL - 1) + NW'(in_off);
									k_q     <= ORD_W'(1);
									state_q <= S_FRD;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_INIT: begin
					if (i_q == NW'(NODES - 1)) begin
						i_q     <= NW'(TL - 2);
						k_q     <= ORD_W'(2);
						state_q <= S_IRL;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_IRL: state_q <= S_IRR;
				S_IRR: begin
					lval_q  <= ord_rdata;
					state_q <= S_IWR;
				end
				S_IWR: begin
					if (i_q == '0) begin
						state_q <= S_RESP;
					end else begin
						// Leaving the first node of a level moves up one order.
						if ((i_q & (i_q + 1'b1)) == '0)
							k_q <= k_q + 1'b1;
						i_q     <= i_q - 1'b1;
						state_q <= S_IRL;
					end
				end
				S_AROOT: state_q <= S_ACHK;
				S_ACHK: begin
					if (need > node_eff(ord_rdata)) begin
						res_status_q <= ST_NO_SPACE;
						state_q      <= S_RESP;
					end else begin
						i_q     <= '0;
						k_q     <= TOP;
						state_q <= (TOP == need) ? S_ATAKE : S_ARD;
					end
				end
				S_ARD: state_q <= S_ADN;
				S_ADN: begin
					i_q     <= (node_eff(ord_rdata) >= need) ? lchild : rchild;
					k_q     <= k_q - 1'b1;
					state_q <= (k_q - 1'b1 == need) ? S_ATAKE : S_ARD;
				end
				S_ATAKE: begin
					cur_q   <= '0;
					state_q <= S_AREF;
				end
				S_AREF: begin
					res_aoff_q <= 10'(aoff);
					fc_q       <= (fc_q > bsize) ? fc_q - bsize : '0;
					state_q    <= (i_q == '0) ? S_RESP : S_URD;
				end
				S_URD: state_q <= S_UWR;
				S_UWR: begin
					cur_q   <= merged;
					i_q     <= parent;
					k_q     <= k_q + 1'b1;
					state_q <= (parent == '0) ? S_RESP : S_URD;
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (found) begin
						if (op_q == OP_FREE) begin
							cur_q   <= '{inv: 1'b0, ord: k_q};
							fc_q    <= (fc_sum > (FCW + 1)'(TL)) ? FCW'(TL) : fc_sum[FCW-1:0];
							state_q <= (i_q == '0) ? S_RESP : S_URD;
						end else begin
							res_status_q <= nv_ok ? ST_OK : ST_REF_RANGE;
							res_rc_q     <= nv_ok ? nv[6:0] : refs_rdata;
							state_q      <= S_RESP;
						end
					end else if (i_q == '0) begin
						res_status_q <= ST_NOT_ALLOC;
						state_q      <= S_RESP;
					end else begin
						i_q     <= parent;
						k_q     <= k_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, 11'(fc_q), res_rc_q, res_aoff_q, res_status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ src/bpa_checker.sv @@
module bpa_checker
	import bpa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A result that is not taken stays offered, unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Requests are worked on one at a time.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= ST_REF_RANGE)
		else $error("undefined status code");

	// A result with a failing status reports no offset.
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[12:3] == '0)
		else $error("offset reported with a failing status");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ test/buddy_page_allocator_checker.sv @@
module buddy_page_allocator_checker
	import bpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [10:0] cfg_data,
	output int          fail_count,
	output int          outstanding
);

	localparam int TL = 1024;
	localparam int NODES = 2 * TL - 1;
	localparam int TOP_ORD = 11;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  offset;
		logic [6:0]  refs;
		logic [10:0] avail_pages;
	} outcome_t;

	node_t       tree [NODES];
	logic [6:0]  block_refs [NODES];
	int          free_cnt;
	logic [10:0] page_limit;
	outcome_t    awaited [$];

	initial begin
		fail_count = 0;
		free_cnt = 0;
		page_limit = PAGE_COUNT_RST;
		for (int i = 0; i < NODES; i++) begin
			tree[i] = NODE_INV;
			block_refs[i] = '0;
		end
	end

	assign outstanding = awaited.size();

	task automatic report(input string what, input int got, input int want);
		$display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Rebuilds one parent from its two children; a pair of whole free buddies merges.
	function automatic void merge_node(input int i, input int level);
		node_t l, r;
		l = tree[2*i+1];
		r = tree[2*i+2];
		if (!l.inv && !r.inv) begin
			if (l.ord == r.ord && int'(r.ord) + 1 == level)
				tree[i] = '{inv: 1'b0, ord: l.ord + 1'b1};
			else
				tree[i] = (l.ord > r.ord) ? l : r;
		end else if (!r.inv) begin
			tree[i] = r;
		end else if (!l.inv) begin
			tree[i] = l;
		end else begin
			tree[i] = NODE_INV;
		end
	endfunction

	function automatic void climb(input int i, input int level);
		while (i != 0) begin
			i = (i - 1) / 2;
			level++;
			merge_node(i, level);
		end
	endfunction

	function automatic int usable(input node_t n);
		return n.inv ? 0 : int'(n.ord);
	endfunction

	// Walks up from a leaf to the first taken node; returns its index or -1.
	function automatic int taken_above(input int off, output int level);
		int i;
		i = TL - 1 + off;
		level = 1;
		forever begin
			if (!tree[i].inv && tree[i].ord == '0)
				return i;
			if (i == 0)
				return -1;
			i = (i - 1) / 2;
			level++;
		end
	endfunction

	function automatic outcome_t serve(input logic [31:0] word);
		logic [1:0]        op;
		int                req, off, delta, i, k, need, bsize, nv, cnt;
		outcome_t          res;
		op = word[1:0];
		req = int'(word[12:2]);
		off = int'(word[22:13]);
		delta = int'($signed(word[30:23]));
		res = '0;
		res.status = ST_OK;
		case (op)
		OP_INIT: begin
			for (i = 0; i < NODES; i++)
				block_refs[i] = '0;
			for (i = 0; i < TL; i++)
				tree[TL-1+i] = '{inv: (i >= int'(page_limit)), ord: 5'd1};
			k = 2;
			for (cnt = TL / 2; cnt >= 1; cnt = cnt / 2) begin
				for (i = 0; i < cnt; i++)
					merge_node(cnt - 1 + i, k);
				k++;
			end
			free_cnt = (int'(page_limit) < TL) ? int'(page_limit) : TL;
		end
		OP_ALLOC: begin
			if (req == 0) begin
				res.status = ST_ZERO_SIZE;
			end else begin
				need = 1;
				while ((1 << (need - 1)) < req)
					need++;
				if (need > usable(tree[0])) begin
					res.status = ST_NO_SPACE;
				end else begin
					i = 0;
					k = TOP_ORD;
					while (k != need) begin
						i = (usable(tree[2*i+1]) >= need) ? 2*i+1 : 2*i+2;
						k--;
					end
					tree[i] = '{inv: 1'b0, ord: '0};
					if (block_refs[i] < REF_MAX)
						block_refs[i]++;
					bsize = 1 << (k - 1);
					res.offset = 10'((i + 1) * bsize - TL);
					climb(i, k);
					free_cnt = (free_cnt > bsize) ? free_cnt - bsize : 0;
				end
			end
		end
		OP_FREE: begin
			i = taken_above(off, k);
			if (i < 0) begin
				res.status = ST_NOT_ALLOC;
			end else begin
				tree[i] = '{inv: 1'b0, ord: 5'(k)};
				if (block_refs[i] > 0)
					block_refs[i]--;
				free_cnt += 1 << (k - 1);
				if (free_cnt > TL)
					free_cnt = TL;
				climb(i, k);
			end
		end
		default: begin
			i = taken_above(off, k);
			if (i < 0) begin
				res.status = ST_NOT_ALLOC;
			end else begin
				nv = int'(block_refs[i]) + delta;
				if (nv < 1 || nv > int'(REF_MAX))
					res.status = ST_REF_RANGE;
				else
					block_refs[i] = 7'(nv);
				res.refs = block_refs[i];
			end
		end
		endcase
		res.avail_pages = 11'(free_cnt);
		return res;
	endfunction

	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				page_limit = cfg_data;
			if (s_tvalid && s_tready)
				awaited.push_back(serve(s_tdata));
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[2:0];
				got.offset = m_tdata[12:3];
				got.refs = m_tdata[19:13];
				got.avail_pages = m_tdata[30:20];
				if (awaited.size() == 0) begin
					report("result with nothing pending, status", got.status, -1);
				end else begin
					want = awaited.pop_front();
					if (got.status != want.status)
						report("status", got.status, want.status);
					if (got.offset != want.offset)
						report("alloc_offset", got.offset, want.offset);
					if (got.refs != want.refs)
						report("ref_count", got.refs, want.refs);
					if (got.avail_pages != want.avail_pages)
						report("avail_pages", got.avail_pages, want.avail_pages);
				end
			end
		end
	end

endmodule

@@ test/buddy_page_allocator_tb.sv @@
module buddy_page_allocator_tb;
	import bpa_pkg::*;

	localparam int STALL_LIMIT = 30000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] cfg_data;
	int          fail_count;
	int          outstanding;
	int          quiet_cycles = 0;
	int          sink_hold = 0;
	logic        steady;
	logic [10:0] pages_now;

	buddy_page_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	buddy_page_allocator_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	// The result side stalls with the same gap profile, or never while steady is set.
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			m_tready = 1'b0;
			sink_hold--;
		end else begin
			m_tready = 1'b1;
			if (!steady && $urandom_range(0, 3) == 0)
				sink_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send(input logic [1:0] op, input int req, input int off, input int delta);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {1'b0, 8'(delta), 10'(off), 11'(req), op};
		while (!s_tready)
			@(negedge clk);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Register writes happen only with nothing in flight.
	task automatic set_pages(input logic [10:0] value);
		drain();
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		while (!cfg_ready)
			@(negedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		pages_now = value;
	endtask

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 92)
			return $urandom_range(9, 128);
		if (r < 97)
			return $urandom_range(129, 1024);
		return 0;
	endfunction

	function automatic int pick_offset();
		if (pages_now > 0 && pages_now <= 1024 && $urandom_range(0, 9) != 0)
			return $urandom_range(0, pages_now - 1);
		return $urandom_range(0, 1023);
	endfunction

	task automatic random_phase(input logic [10:0] pages, input int count);
		int r;
		set_pages(pages);
		steady = ($urandom_range(0, 3) == 0);
		send(OP_INIT, 0, 0, 0);
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				drain();
			r = $urandom_range(0, 99);
			if (r < 45)
				send(OP_ALLOC, pick_size(), $urandom_range(0, 1023), $urandom_range(0, 255));
			else if (r < 80)
				send(OP_FREE, $urandom_range(0, 1024), pick_offset(), $urandom_range(0, 255));
			else if (r < 99)
				send(OP_CREF, $urandom_range(0, 1024), pick_offset(),
					$urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
					: $urandom_range(0, 4) - 2);
			else
				send(OP_INIT, 0, 0, 0);
		end
		steady = 1'b0;
	endtask

	initial begin
		logic [10:0] choices [6];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		steady = 1'b0;
		pages_now = PAGE_COUNT_RST;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Before the first init the whole tree is invalid.
		send(OP_ALLOC, 1, 0, 0);
		send(OP_FREE, 0, 0, 0);
		send(OP_CREF, 0, 0, 5);
		send(OP_INIT, 0, 0, 0);
		send(OP_ALLOC, 0, 0, 0);
		send(OP_ALLOC, 1024, 0, 0);
		send(OP_ALLOC, 1, 0, 0);
		send(OP_CREF, 0, 1023, 127);
		send(OP_CREF, 0, 1023, -1);
		send(OP_CREF, 0, 512, 126);
		send(OP_CREF, 0, 0, -127);
		send(OP_FREE, 0, 1023, 0);
		send(OP_FREE, 0, 0, 0);
		send(OP_ALLOC, 3, 0, 0);
		send(OP_ALLOC, 1, 0, 0);
		send(OP_ALLOC, 513, 0, 0);
		send(OP_FREE, 0, 2, 0);
		send(OP_ALLOC, 2047, 0, 0);
		set_pages(11'd0);
		send(OP_INIT, 0, 0, 0);
		send(OP_ALLOC, 1, 0, 0);
		set_pages(11'd2047);
		send(OP_INIT, 0, 0, 0);
		send(OP_ALLOC, 1024, 0, 0);
		set_pages(11'd1000);
		send(OP_INIT, 0, 0, 0);
		send(OP_ALLOC, 512, 0, 0);
		send(OP_ALLOC, 512, 0, 0);

		choices = '{11'd1024, 11'd1, 11'd2047, 11'd1023, 11'd0, 11'd640};
		for (int p = 0; p < 6; p++)
			random_phase(p == 5 ? 11'($urandom_range(2, 1024)) : choices[p], 210);

		drain();
		repeat (60) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
